@@ rtl/core/msrt_pkg.sv @@
package msrt_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int PH_W      = $clog2(MAX_ITEMS);

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
    } entry_t;

    // Per-cell control. The top cell never acts as the lower cell of a pair.
    typedef struct packed {
        logic shift;
        logic lower;
        logic upper;
        logic desc;
    } cell_ctrl_t;

    // True when a must come out strictly before b in the chosen order.
    function automatic logic strict_before(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic                     desc
    );
        logic result;
        if (desc)
        begin
            result = (a > b);
        end
        else
        begin
            result = (a < b);
        end
        return result;
    endfunction

endpackage

@@ rtl/core/msrt_cell.sv @@
module msrt_cell
    import msrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     prev_entry,
    input  entry_t     next_entry,
    input  logic       swap_in,
    output logic       swap_out,
    output entry_t     entry
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // The higher cell of a pair holds the entry that leaves first. A valid
    // entry always moves above an empty one; equal values never trade places,
    // so earlier arrivals stay above later ones.
    always_comb
    begin
        swap_out = 1'b0;
        if (ctrl.lower && valid_reg)
        begin
            swap_out = !next_entry.valid ||
                       strict_before(value_reg, next_entry.value, ctrl.desc);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        priority if (ctrl.shift)
        begin
            valid_next = prev_entry.valid;
            value_next = prev_entry.value;
        end
        else if (swap_out)
        begin
            valid_next = next_entry.valid;
            value_next = next_entry.value;
        end
        else if (ctrl.upper && swap_in)
        begin
            valid_next = prev_entry.valid;
            value_next = prev_entry.value;
        end
        else
        begin
            valid_next = valid_reg;
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign entry.valid = valid_reg;
    assign entry.value = value_reg;

endmodule

@@ rtl/core/merge_sorter.sv @@
// Items are loaded while the block is in the load state. After the last item the row of cells runs
// MAX_ITEMS odd-even transposition phases, one per cycle, and then offers the sorted results;
// results leave one per cycle while m_tready is high.
// Asynchronous active-low reset empties all cells, clears the count and overflow flag,
// and selects ascending order.
module merge_sorter
    import msrt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // cfg_data: [0] descending
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_data,
    // s_tdata: [31:0] value
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tlast,
    // m_tdata: [31:0] sorted_value
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tlast,
    // m_tuser: [0] overflowed
    output logic [0:0]        m_tuser
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PH_W-1:0] phase_reg;
    logic [PH_W-1:0] phase_next;
    logic            overflow_reg;
    logic            overflow_next;
    logic            desc_reg;

    logic   in_xfer;
    logic   out_xfer;
    logic   store;
    logic   shift;
    logic   sorting;
    entry_t in_entry;
    entry_t empty_entry;

    entry_t     cells   [MAX_ITEMS];
    logic       swaps   [MAX_ITEMS];
    cell_ctrl_t ctrls   [MAX_ITEMS];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_LOAD);
    assign m_tvalid  = (state_reg == ST_EMIT);

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign store    = in_xfer && (count_reg != CNT_W'(MAX_ITEMS));
    assign shift    = store || out_xfer;
    assign sorting  = (state_reg == ST_SORT);

    assign in_entry.valid    = store;
    assign in_entry.value    = $signed(s_tdata);
    assign empty_entry.valid = 1'b0;
    assign empty_entry.value = '0;

    assign m_tdata = cells[MAX_ITEMS-1].value;
    assign m_tlast = (count_reg == CNT_W'(1));
    assign m_tuser = overflow_reg;

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        assign ctrls[i].shift = shift;
        assign ctrls[i].desc  = desc_reg;
        assign ctrls[i].lower = sorting && (phase_reg[0] == 1'(i)) && (i < MAX_ITEMS - 1);
        assign ctrls[i].upper = sorting && (phase_reg[0] != 1'(i)) && (i > 0);

        msrt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrls[i]),
            .prev_entry ((i == 0) ? in_entry : cells[(i == 0) ? 0 : i - 1]),
            .next_entry ((i == MAX_ITEMS - 1) ? empty_entry
                                              : cells[(i == MAX_ITEMS - 1) ? i : i + 1]),
            .swap_in    ((i == 0) ? 1'b0 : swaps[(i == 0) ? 0 : i - 1]),
            .swap_out   (swaps[i]),
            .entry      (cells[i])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (store)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_SORT;
                        phase_next = '0;
                    end
                end
            end
            ST_SORT:
            begin
                phase_next = phase_reg + PH_W'(1);
                if (phase_reg == PH_W'(MAX_ITEMS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next    = ST_LOAD;
                        overflow_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            phase_reg    <= '0;
            overflow_reg <= 1'b0;
            desc_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            overflow_reg <= overflow_next;
            if (cfg_valid && cfg_ready)
            begin
                desc_reg <= cfg_data[0];
            end
        end
    end

endmodule
